>>> design/assert_macros.svh
// Assertion macros for the checker module of the PNG chunk deframer.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising clock edge, masked while reset is low.
`define PNGDF_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same check, but also evaluated while reset is asserted.
`define PNGDF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> design/pngdf_pkg.sv
// Shared types, constants and functions of the PNG chunk deframer.
// No dependencies; compile first after the macro header.
package pngdf_pkg;

    localparam int CHUNK_COUNT_WIDTH = 16;
    localparam int IDX_W             = 16;
    localparam int QUEUE_DEPTH       = 4;
    localparam int QPTR_W            = $clog2(QUEUE_DEPTH);

    localparam logic [IDX_W-1:0] IDX_MAX   = {IDX_W{1'b1}};
    localparam logic [31:0]      TYPE_IHDR = 32'h4948_4452;
    localparam logic [31:0]      TYPE_IEND = 32'h4945_4E44;
    localparam logic [31:0]      CRC_INIT  = 32'hFFFF_FFFF;
    localparam logic [31:0]      CRC_POLY  = 32'hEDB8_8320;

    // Configuration register indexes
    localparam logic [7:0] CFG_STOP_ON_CRC_FAIL     = 8'd0;
    localparam logic [7:0] CFG_REQUIRE_HEADER_FIRST = 8'd1;

    typedef enum logic [2:0] {
        PH_SIG,
        PH_LEN,
        PH_TYPE,
        PH_DATA,
        PH_CRC,
        PH_DONE
    } t_phase;

    typedef enum logic [1:0] {
        ERR_NONE,
        ERR_SIG,
        ERR_HDR,
        ERR_TRUNC
    } t_err;

    typedef enum logic {
        KIND_CHUNK,
        KIND_ERROR
    } t_kind;

    typedef struct packed {
        logic stop_on_crc_fail;
        logic require_header_first;
    } t_cfg;

    typedef struct packed {
        t_kind            kind;
        logic [IDX_W-1:0] idx;
        logic [31:0]      len;
        logic [31:0]      typ;
        logic [31:0]      crc;
        logic             ok;
        t_err             err;
        logic             fin;
    } t_record;

    // PNG file signature, one byte per position
    function automatic logic [7:0] sig_byte(input logic [2:0] pos);
        logic [7:0] v;
        case (pos)
            3'd0:    v = 8'h89;
            3'd1:    v = 8'h50;
            3'd2:    v = 8'h4e;
            3'd3:    v = 8'h47;
            3'd4:    v = 8'h0d;
            3'd5:    v = 8'h0a;
            3'd6:    v = 8'h1a;
            default: v = 8'h0a;
        endcase
        return v;
    endfunction

    // Reflected CRC-32, one byte per call
    function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] v;
        v = c ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
        end
        return v;
    endfunction

endpackage

>>> design/pngdf_front.sv
// Byte parser of the PNG chunk deframer: signature, chunk framing, CRC.
// Depends on pngdf_pkg; emits one record per chunk or error into the queue.
module pngdf_front import pngdf_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_fire,
    input  logic [7:0] i_byte,
    input  logic    i_last,
    input  t_cfg    i_cfg,
    output logic    o_push,
    output t_record o_rec
);

    localparam int XW = (CHUNK_COUNT_WIDTH > IDX_W) ? CHUNK_COUNT_WIDTH : IDX_W;
    localparam logic [CHUNK_COUNT_WIDTH-1:0] CNT_MAX = {CHUNK_COUNT_WIDTH{1'b1}};

    t_phase r_phase, n_phase;
    logic [31:0] r_pos, n_pos;
    logic [31:0] r_len, n_len;
    logic [31:0] r_type, n_type;
    logic [31:0] r_crc_sh, n_crc_sh;
    logic [31:0] r_crc, n_crc;
    logic [CHUNK_COUNT_WIDTH-1:0] r_cnt, n_cnt;

    logic [XW-1:0] cnt_x;
    logic          emit, fin, ok;
    t_kind         kind;
    t_err          err;
    logic [31:0]   pos_inc;

    assign cnt_x   = XW'(r_cnt);
    assign pos_inc = r_pos + 32'd1;

    // Hold parser state; advance only on an accepted byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_SIG;
            r_pos    <= '0;
            r_len    <= '0;
            r_type   <= '0;
            r_crc_sh <= '0;
            r_crc    <= CRC_INIT;
            r_cnt    <= '0;
        end else if (i_fire) begin
            r_phase  <= n_phase;
            r_pos    <= n_pos;
            r_len    <= n_len;
            r_type   <= n_type;
            r_crc_sh <= n_crc_sh;
            r_crc    <= n_crc;
            r_cnt    <= n_cnt;
        end
    end

    // Next state and record for the byte on the input
    always_comb begin
        n_phase  = r_phase;
        n_pos    = r_pos;
        n_len    = r_len;
        n_type   = r_type;
        n_crc_sh = r_crc_sh;
        n_crc    = r_crc;
        n_cnt    = r_cnt;
        emit     = 1'b0;
        fin      = 1'b0;
        ok       = 1'b0;
        kind     = KIND_CHUNK;
        err      = ERR_NONE;

        case (r_phase)
            PH_SIG: begin
                if (i_byte != sig_byte(r_pos[2:0])) begin
                    emit = 1'b1;
                    fin  = 1'b1;
                    kind = KIND_ERROR;
                    err  = ERR_SIG;
                end else if (r_pos[2:0] == 3'd7) begin
                    n_phase = PH_LEN;
                    n_pos   = '0;
                end else begin
                    n_pos = pos_inc;
                end
            end
            PH_LEN: begin
                n_len = {r_len[23:0], i_byte};
                if (r_pos[1:0] == 2'd3) begin
                    n_phase = PH_TYPE;
                    n_pos   = '0;
                    n_crc   = CRC_INIT;
                end else begin
                    n_pos = pos_inc;
                end
            end
            PH_TYPE: begin
                n_type = {r_type[23:0], i_byte};
                n_crc  = crc_byte(r_crc, i_byte);
                if (r_pos[1:0] == 2'd3) begin
                    n_pos = '0;
                    if (r_cnt == '0 && i_cfg.require_header_first && n_type != TYPE_IHDR) begin
                        emit = 1'b1;
                        fin  = 1'b1;
                        kind = KIND_ERROR;
                        err  = ERR_HDR;
                    end else begin
                        n_phase = (r_len != '0) ? PH_DATA : PH_CRC;
                    end
                end else begin
                    n_pos = pos_inc;
                end
            end
            PH_DATA: begin
                n_crc = crc_byte(r_crc, i_byte);
                n_pos = pos_inc;
                if (pos_inc == r_len) begin
                    n_phase = PH_CRC;
                    n_pos   = '0;
                end
            end
            PH_CRC: begin
                n_crc_sh = {r_crc_sh[23:0], i_byte};
                n_pos    = pos_inc;
                if (r_pos[1:0] == 2'd3) begin
                    emit = 1'b1;
                    ok   = ((r_crc ^ CRC_INIT) == n_crc_sh);
                    fin  = (r_type == TYPE_IEND) || (!ok && i_cfg.stop_on_crc_fail);
                end
            end
            default: begin
                // finished file: drop bytes until the one flagged last
            end
        endcase

        // A last byte either completes a record or ends the file early
        if (r_phase != PH_DONE && i_last) begin
            if (!emit) begin
                emit = 1'b1;
                fin  = 1'b1;
                kind = KIND_ERROR;
                err  = ERR_TRUNC;
            end else if (!fin) begin
                err = ERR_TRUNC;
                fin = 1'b1;
            end
        end

        o_rec.kind = kind;
        o_rec.idx  = (cnt_x > XW'(IDX_MAX)) ? IDX_MAX : cnt_x[IDX_W-1:0];
        o_rec.len  = n_len;
        o_rec.typ  = n_type;
        o_rec.crc  = n_crc_sh;
        o_rec.ok   = ok;
        o_rec.err  = err;
        o_rec.fin  = fin;

        // Chunk done: count it and rearm for the next length field
        if (r_phase == PH_CRC && r_pos[1:0] == 2'd3) begin
            if (r_cnt != CNT_MAX) begin
                n_cnt = r_cnt + 1'b1;
            end
            n_phase  = PH_LEN;
            n_pos    = '0;
            n_len    = '0;
            n_type   = '0;
            n_crc_sh = '0;
            n_crc    = CRC_INIT;
        end

        if (emit && fin) begin
            n_phase = PH_DONE;
        end

        // Rearm on the last byte of the file
        if (i_last) begin
            n_phase  = PH_SIG;
            n_pos    = '0;
            n_len    = '0;
            n_type   = '0;
            n_crc_sh = '0;
            n_crc    = CRC_INIT;
            n_cnt    = '0;
        end
    end

    assign o_push = i_fire && emit;

endmodule

>>> design/pngdf_queue.sv
// Short record queue between the byte parser and the output stage.
// Depends on pngdf_pkg for the record type and depth.
module pngdf_queue import pngdf_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_record i_rec,
    output logic    o_space,
    input  logic    i_pop,
    output logic    o_valid,
    output t_record o_rec
);

    t_record r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QPTR_W:0]   r_count;

    assign o_space = (r_count != (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_rec   = r_mem[r_rd];

    // Store pushed records
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_rec;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

>>> design/pngdf_back.sv
// Output stage: formats queued records and holds them for the stream sink.
// Depends on pngdf_pkg for the record type and codes.
module pngdf_back import pngdf_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_record i_rec,
    output logic    o_pop,
    input  logic    i_ready,
    output logic    o_valid,
    output t_record o_rec
);

    logic    r_valid;
    t_record r_rec, n_rec;

    assign o_pop   = i_valid && (!r_valid || i_ready);
    assign o_valid = r_valid;
    assign o_rec   = r_rec;

    // Error records carry no CRC verdict; header errors carry no trailer
    always_comb begin
        n_rec = i_rec;
        if (i_rec.kind == KIND_ERROR) begin
            n_rec.ok = 1'b0;
            if (i_rec.err == ERR_HDR) begin
                n_rec.crc = '0;
            end
        end
    end

    // Load a record when the register is empty or being taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rec <= n_rec;
        end
    end

endmodule

>>> design/png_chunk_deframer_crc_check_top.sv
// PNG chunk deframer with CRC-32 check. Takes one file byte per transfer and
// returns at most one record per byte. The parser takes one byte every cycle:
// the per-byte CRC update, the 32-bit data counter and the framing compares
// all settle combinationally ahead of the state registers. The input stalls only while the four-entry
// record queue is full, that is when the record sink holds back for several
// records in a row. No clearing pass: the block takes bytes as soon as reset
// is released.
// Depends on pngdf_pkg, pngdf_front, pngdf_queue and pngdf_back.
module png_chunk_deframer_crc_check_top import pngdf_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // byte stream
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [7:0] data_byte
    input  logic         s_axis_tlast,   // last_byte
    // record stream
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [15:0] chunk_index, [47:16] chunk_length, [79:48] chunk_type,
    // [111:80] stored_crc, [112] crc_ok, [114:113] error_code, [119:115] zero
    output logic [119:0] m_axis_tdata,
    output logic         m_axis_tlast,   // final_res
    output logic         m_axis_tuser,   // record_kind
    // configuration writes
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [7:0]   i_cfg_index,
    input  logic         i_cfg_data
);

    t_cfg    r_cfg;
    logic    in_fire;
    logic    q_space, q_push, q_pop, q_valid;
    t_record f_rec, q_rec, b_rec;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = q_space;
    assign in_fire       = s_axis_tvalid && q_space;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.stop_on_crc_fail     <= 1'b1;
            r_cfg.require_header_first <= 1'b1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_STOP_ON_CRC_FAIL:     r_cfg.stop_on_crc_fail     <= i_cfg_data;
                CFG_REQUIRE_HEADER_FIRST: r_cfg.require_header_first <= i_cfg_data;
                default:                  r_cfg                      <= r_cfg;
            endcase
        end
    end

    pngdf_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (in_fire),
        .i_byte  (s_axis_tdata),
        .i_last  (s_axis_tlast),
        .i_cfg   (r_cfg),
        .o_push  (q_push),
        .o_rec   (f_rec)
    );

    pngdf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_rec   (f_rec),
        .o_space (q_space),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_rec   (q_rec)
    );

    pngdf_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_rec   (q_rec),
        .o_pop   (q_pop),
        .i_ready (m_axis_tready),
        .o_valid (m_axis_tvalid),
        .o_rec   (b_rec)
    );

    // Pack the record onto the stream
    assign m_axis_tdata = {5'd0, b_rec.err, b_rec.ok, b_rec.crc, b_rec.typ,
                           b_rec.len, b_rec.idx};
    assign m_axis_tlast = b_rec.fin;
    assign m_axis_tuser = b_rec.kind;

endmodule

>>> design/pngdf_checker.sv
// Port-level checks of the PNG chunk deframer, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module pngdf_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [119:0] m_axis_tdata,
    input logic         m_axis_tlast,
    input logic         m_axis_tuser
);

    // An error record always ends the file
    `PNGDF_ASSERT(a_err_is_final, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser |-> m_axis_tlast, "error record without final flag")

    // An error record never reports a good CRC
    `PNGDF_ASSERT(a_err_no_ok, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser |-> !m_axis_tdata[112], "error record with crc_ok set")

    // An error record carries an error code
    `PNGDF_ASSERT(a_err_has_code, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[114:113] != 2'd0, "error record with no code")

    // A stalled record holds
    `PNGDF_ASSERT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled record changed")

endmodule

bind png_chunk_deframer_crc_check_top pngdf_checker u_pngdf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);
